// ===== rtl/core/vrp_pkg.sv =====
// shared widths, register indexes and reset values for the vertex transform core
// no dependencies
package vrp_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned TrigW  = 16;
  localparam int unsigned ScaleW = 32;
  localparam int unsigned RxW    = 23;  // rotated x, scale 2^-16
  localparam int unsigned RzW    = 25;  // rotated y and z, scale 2^-16
  localparam int unsigned NumW   = 58;  // projected numerator, scale 2^-32
  localparam int unsigned DenW   = RzW;
  localparam int unsigned QuoW   = NumW + 1;
  localparam int unsigned Lanes  = 3;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 32;

  localparam int unsigned DefScreenWidth  = 84;
  localparam int unsigned DefScreenHeight = 48;

  typedef enum logic [CfgIdxW-1:0] {
    RegCosZ   = 8'd0,
    RegSinZ   = 8'd1,
    RegCosX   = 8'd2,
    RegSinX   = 8'd3,
    RegProjX  = 8'd4,
    RegProjY  = 8'd5,
    RegDepthS = 8'd6,
    RegDepthO = 8'd7
  } cfg_reg_e;

  localparam logic signed [TrigW-1:0]  TrigOne  = 16'sd16384;
  localparam logic signed [ScaleW-1:0] ScaleOne = 32'sd65536;

  typedef struct packed {
    logic signed [TrigW-1:0]  cos_z;
    logic signed [TrigW-1:0]  sin_z;
    logic signed [TrigW-1:0]  cos_x;
    logic signed [TrigW-1:0]  sin_x;
    logic signed [ScaleW-1:0] proj_x;
    logic signed [ScaleW-1:0] proj_y;
    logic signed [ScaleW-1:0] depth_s;
    logic signed [ScaleW-1:0] depth_o;
  } cfg_t;

endpackage

// ===== rtl/core/vrp_rotate.sv =====
// four-stage rotation about z and then about x, floored to scale 2^-16
// depends on vrp_pkg
module vrp_rotate import vrp_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     advance_i,
  input  logic                     valid_i,
  input  logic signed [CoordW-1:0] x_i,
  input  logic signed [CoordW-1:0] y_i,
  input  logic signed [CoordW-1:0] z_i,
  input  cfg_t                     cfg_i,
  output logic                     valid_o,
  output logic signed [RxW-1:0]    rx_o,
  output logic signed [RzW-1:0]    ry_o,
  output logic signed [RzW-1:0]    rz_o
);

  logic [3:0] vld_q;

  // stage 1: z rotation products
  logic signed [31:0] xcz_q, ysz_q, xsz_q, ycz_q;
  logic signed [CoordW-1:0] z1_q;
  // stage 2: z rotation sums
  logic signed [32:0] x1_q, y1_q;
  logic signed [CoordW-1:0] z2_q;
  // stage 3: x rotation products
  logic signed [48:0] ycx_q, ysx_q;
  logic signed [31:0] zsx_q, zcx_q;
  logic signed [RxW-1:0] rx3_q;
  // stage 4: x rotation sums, floored
  logic signed [RxW-1:0] rx_q;
  logic signed [RzW-1:0] ry_q, rz_q;

  logic signed [49:0] y2, z2;

  always_comb begin
    y2 = {ycx_q[48], ycx_q} - {{4{zsx_q[31]}}, zsx_q, 14'b0};
    z2 = {ysx_q[48], ysx_q} + {{4{zcx_q[31]}}, zcx_q, 14'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (advance_i) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      xcz_q <= x_i * cfg_i.cos_z;
      ysz_q <= y_i * cfg_i.sin_z;
      xsz_q <= x_i * cfg_i.sin_z;
      ycz_q <= y_i * cfg_i.cos_z;
      z1_q  <= z_i;

      x1_q <= {xcz_q[31], xcz_q} - {ysz_q[31], ysz_q};
      y1_q <= {xsz_q[31], xsz_q} + {ycz_q[31], ycz_q};
      z2_q <= z1_q;

      ycx_q <= y1_q * cfg_i.cos_x;
      ysx_q <= y1_q * cfg_i.sin_x;
      zsx_q <= z2_q * cfg_i.sin_x;
      zcx_q <= z2_q * cfg_i.cos_x;
      rx3_q <= x1_q[32:10];

      rx_q <= rx3_q;
      ry_q <= y2[48:24];
      rz_q <= z2[48:24];
    end
  end

  assign valid_o = vld_q[3];
  assign rx_o    = rx_q;
  assign ry_o    = ry_q;
  assign rz_o    = rz_q;

endmodule

// ===== rtl/core/vrp_project.sv =====
// three-stage projection: scale products, depth offset, then sign and magnitude
// for the divider; a zero w turns into a divide by one of the numerator floored
// by 2^16. depends on vrp_pkg
module vrp_project import vrp_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   advance_i,
  input  logic                   valid_i,
  input  logic signed [RxW-1:0]  rx_i,
  input  logic signed [RzW-1:0]  ry_i,
  input  logic signed [RzW-1:0]  rz_i,
  input  cfg_t                   cfg_i,
  output logic                   valid_o,
  output logic [NumW-1:0]        num_mag_o [Lanes],
  output logic                   neg_o     [Lanes],
  output logic [DenW-1:0]        den_mag_o,
  output logic                   wzero_o
);

  logic [2:0] vld_q;

  logic signed [54:0] px_q;
  logic signed [56:0] py_q, pzm_q;
  logic signed [RzW-1:0] rz5_q;
  logic wz5_q;

  logic signed [NumW-1:0] num6_q [Lanes];
  logic signed [DenW-1:0] den6_q;
  logic wz6_q;

  logic [NumW-1:0] mag_q [Lanes];
  logic neg_q [Lanes];
  logic [DenW-1:0] dmag_q;
  logic wz7_q;

  logic signed [NumW-1:0] full [Lanes];
  logic signed [NumW-1:0] sel [Lanes];

  always_comb begin
    full[0] = {{3{px_q[54]}}, px_q};
    full[1] = {py_q[56], py_q};
    full[2] = {pzm_q[56], pzm_q} + {{10{cfg_i.depth_o[31]}}, cfg_i.depth_o, 16'b0};
    for (int l = 0; l < Lanes; l++) begin
      sel[l] = wz5_q ? {{16{full[l][NumW-1]}}, full[l][NumW-1:16]} : full[l];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (advance_i) begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      px_q  <= rx_i * cfg_i.proj_x;
      py_q  <= ry_i * cfg_i.proj_y;
      pzm_q <= rz_i * cfg_i.depth_s;
      rz5_q <= rz_i;
      wz5_q <= (rz_i == '0);

      for (int l = 0; l < Lanes; l++) begin
        num6_q[l] <= sel[l];
      end
      den6_q <= wz5_q ? DenW'(1) : rz5_q;
      wz6_q  <= wz5_q;

      for (int l = 0; l < Lanes; l++) begin
        mag_q[l] <= num6_q[l][NumW-1] ? NumW'(-num6_q[l]) : NumW'(num6_q[l]);
        neg_q[l] <= num6_q[l][NumW-1] ^ den6_q[DenW-1];
      end
      dmag_q <= den6_q[DenW-1] ? DenW'(-den6_q) : DenW'(den6_q);
      wz7_q  <= wz6_q;
    end
  end

  assign valid_o   = vld_q[2];
  assign num_mag_o = mag_q;
  assign neg_o     = neg_q;
  assign den_mag_o = dmag_q;
  assign wzero_o   = wz7_q;

endmodule

// ===== rtl/core/vrp_divider.sv =====
// restoring divider, one quotient bit per stage for three numerators sharing a
// divisor, then a floor correction stage. depends on vrp_pkg
module vrp_divider import vrp_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   advance_i,
  input  logic                   valid_i,
  input  logic [NumW-1:0]        num_mag_i [Lanes],
  input  logic                   neg_i     [Lanes],
  input  logic [DenW-1:0]        den_mag_i,
  input  logic                   wzero_i,
  output logic                   valid_o,
  output logic signed [QuoW-1:0] quo_o [Lanes],
  output logic                   wzero_o
);

  logic            vld_q [NumW];
  logic            wz_q  [NumW];
  logic [DenW-1:0] den_q [NumW];
  logic [DenW-1:0] rem_q [NumW][Lanes];
  logic [NumW-1:0] nq_q  [NumW][Lanes];
  logic            neg_q [NumW][Lanes];

  for (genvar k = 0; k < NumW; k++) begin : g_stage
    logic            vld_in, wz_in;
    logic [DenW-1:0] den_in;
    logic [DenW-1:0] rem_in [Lanes];
    logic [NumW-1:0] nq_in  [Lanes];
    logic            neg_in [Lanes];
    logic [DenW-1:0] rem_nx [Lanes];
    logic [NumW-1:0] nq_nx  [Lanes];

    if (k == 0) begin : g_first
      assign vld_in = valid_i;
      assign wz_in  = wzero_i;
      assign den_in = den_mag_i;
      for (genvar l = 0; l < Lanes; l++) begin : g_lane
        assign rem_in[l] = '0;
        assign nq_in[l]  = num_mag_i[l];
        assign neg_in[l] = neg_i[l];
      end
    end else begin : g_next
      assign vld_in = vld_q[k-1];
      assign wz_in  = wz_q[k-1];
      assign den_in = den_q[k-1];
      for (genvar l = 0; l < Lanes; l++) begin : g_lane
        assign rem_in[l] = rem_q[k-1][l];
        assign nq_in[l]  = nq_q[k-1][l];
        assign neg_in[l] = neg_q[k-1][l];
      end
    end

    always_comb begin
      logic [DenW:0] shifted;
      logic [DenW:0] trial;
      for (int l = 0; l < Lanes; l++) begin
        shifted = {rem_in[l], nq_in[l][NumW-1]};
        trial   = shifted - {1'b0, den_in};
        if (!trial[DenW]) begin
          rem_nx[l] = trial[DenW-1:0];
          nq_nx[l]  = {nq_in[l][NumW-2:0], 1'b1};
        end else begin
          rem_nx[l] = shifted[DenW-1:0];
          nq_nx[l]  = {nq_in[l][NumW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (advance_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (advance_i) begin
        wz_q[k]  <= wz_in;
        den_q[k] <= den_in;
        for (int l = 0; l < Lanes; l++) begin
          rem_q[k][l] <= rem_nx[l];
          nq_q[k][l]  <= nq_nx[l];
          neg_q[k][l] <= neg_in[l];
        end
      end
    end
  end

  // floor correction: a negative quotient with a remainder rounds one further down
  logic                   vld_f_q;
  logic                   wz_f_q;
  logic signed [QuoW-1:0] quo_q [Lanes];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_f_q <= 1'b0;
    end else if (advance_i) begin
      vld_f_q <= vld_q[NumW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      wz_f_q <= wz_q[NumW-1];
      for (int l = 0; l < Lanes; l++) begin
        if (!neg_q[NumW-1][l]) begin
          quo_q[l] <= {1'b0, nq_q[NumW-1][l]};
        end else if (rem_q[NumW-1][l] != '0) begin
          quo_q[l] <= ~{1'b0, nq_q[NumW-1][l]};
        end else begin
          quo_q[l] <= -{1'b0, nq_q[NumW-1][l]};
        end
      end
    end
  end

  assign valid_o = vld_f_q;
  assign quo_o   = quo_q;
  assign wzero_o = wz_f_q;

endmodule

// ===== rtl/core/vrp_viewport.sv =====
// three-stage viewport mapping and depth saturation; the last stage is the
// output register. depends on vrp_pkg
module vrp_viewport import vrp_pkg::*; #(
  parameter int unsigned SCREEN_WIDTH  = DefScreenWidth,
  parameter int unsigned SCREEN_HEIGHT = DefScreenHeight
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     advance_i,
  input  logic                     valid_i,
  input  logic signed [QuoW-1:0]   quo_i [Lanes],
  input  logic                     wzero_i,
  output logic                     valid_o,
  output logic signed [CoordW-1:0] screen_x_o,
  output logic signed [CoordW-1:0] screen_y_o,
  output logic signed [ScaleW-1:0] depth_o,
  output logic                     wzero_o
);

  localparam int unsigned SizeW  = $clog2((SCREEN_WIDTH > SCREEN_HEIGHT ?
                                           SCREEN_WIDTH : SCREEN_HEIGHT) + 1) + 1;
  localparam int unsigned NdcW   = 42;
  localparam int unsigned ProdW  = NdcW + SizeW;
  localparam int unsigned ShiftW = ProdW - 17;
  localparam logic signed [SizeW-1:0] SizeX = SizeW'(SCREEN_WIDTH);
  localparam logic signed [SizeW-1:0] SizeY = SizeW'(SCREEN_HEIGHT);
  localparam logic signed [QuoW-1:0] NdcHi = QuoW'(64'sd1 <<< 40);
  localparam logic signed [QuoW-1:0] NdcLo = -NdcHi;
  localparam logic signed [QuoW-1:0] DepHi = QuoW'(64'sd2147483647);
  localparam logic signed [QuoW-1:0] DepLo = QuoW'(-64'sd2147483648);
  localparam logic signed [ShiftW-1:0] PixHi = ShiftW'(32767);
  localparam logic signed [ShiftW-1:0] PixLo = ShiftW'(-32768);

  logic [2:0] vld_q;
  logic [2:0] wz_q;

  logic signed [NdcW-1:0]   ndc_x_q, ndc_y_q;
  logic signed [ScaleW-1:0] dep1_q, dep2_q, dep3_q;
  logic signed [ProdW-1:0]  prod_x_q, prod_y_q;
  logic signed [CoordW-1:0] sx_q, sy_q;

  function automatic logic signed [NdcW-1:0] ndc_bias(logic signed [QuoW-1:0] v);
    logic signed [QuoW-1:0] c;
    c = (v > NdcHi) ? NdcHi : ((v < NdcLo) ? NdcLo : v);
    return NdcW'(c) + NdcW'(65536);
  endfunction

  function automatic logic signed [CoordW-1:0] pix_sat(logic signed [ProdW-1:0] p);
    logic signed [ShiftW-1:0] s;
    s = p[ProdW-1:17];
    return (s > PixHi) ? CoordW'(PixHi) : ((s < PixLo) ? CoordW'(PixLo) : CoordW'(s));
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (advance_i) begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      wz_q    <= {wz_q[1:0], wzero_i};
      ndc_x_q <= ndc_bias(quo_i[0]);
      ndc_y_q <= ndc_bias(quo_i[1]);
      dep1_q  <= (quo_i[2] > DepHi) ? ScaleW'(DepHi) :
                 ((quo_i[2] < DepLo) ? ScaleW'(DepLo) : ScaleW'(quo_i[2]));

      prod_x_q <= ndc_x_q * SizeX;
      prod_y_q <= ndc_y_q * SizeY;
      dep2_q   <= dep1_q;

      sx_q   <= pix_sat(prod_x_q);
      sy_q   <= pix_sat(prod_y_q);
      dep3_q <= dep2_q;
    end
  end

  assign valid_o    = vld_q[2];
  assign screen_x_o = sx_q;
  assign screen_y_o = sy_q;
  assign depth_o    = dep3_q;
  assign wzero_o    = wz_q[2];

endmodule

// ===== rtl/core/vertex_rotate_project_viewport_core.sv =====
// top level of the vertex transform core: configuration registers and the
// rotate, project, divide and viewport pipeline. depends on vrp_pkg and all vrp_* modules
//
// usage
// - slave stream carries one model-space vertex per word (x, y, z in Q3.12);
//   master stream returns one word per vertex: pixel x, pixel y, Q16.16 depth,
//   and a tuser flag set when the rotated z was zero so no divide took place
// - configuration channel writes the eight rotation, projection and depth
//   registers by index; indexes past the last register are taken and dropped.
//   write only while no vertex is in flight
// - from input word to output word a vertex passes 4 rotation stages,
//   3 projection stages, 58 divider stages plus one floor correction stage,
//   and 3 viewport stages. the divider, one quotient bit per stage, is the longest part
// - one vertex per cycle unless the output stalls; the whole pipeline advances together
// - when the receiver stalls with a word waiting, the pipeline holds and
//   s_tready_o drops; nothing is lost or repeated, and bubbles keep their places
// - reset clears every valid bit and loads the identity rotation, unit scales
//   and a zero depth offset
module vertex_rotate_project_viewport_core import vrp_pkg::*; #(
  parameter int unsigned SCREEN_WIDTH  = DefScreenWidth,
  parameter int unsigned SCREEN_HEIGHT = DefScreenHeight
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // vertex input: vertex_x [15:0], vertex_y [31:16], vertex_z [47:32]
  input  logic                s_tvalid_i,
  output logic                s_tready_o,
  input  logic [47:0]         s_tdata_i,
  // result: screen_x [15:0], screen_y [31:16], depth_out [63:32]
  output logic                m_tvalid_o,
  input  logic                m_tready_i,
  output logic [63:0]         m_tdata_o,
  // w_was_zero [0]
  output logic [0:0]          m_tuser_o,
  // register writes
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t cfg_q;
  logic advance;

  // whole pipeline moves unless a finished word sits unaccepted
  assign advance     = !m_tvalid_o || m_tready_i;
  assign s_tready_o  = advance;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cos_z   <= TrigOne;
      cfg_q.sin_z   <= '0;
      cfg_q.cos_x   <= TrigOne;
      cfg_q.sin_x   <= '0;
      cfg_q.proj_x  <= ScaleOne;
      cfg_q.proj_y  <= ScaleOne;
      cfg_q.depth_s <= ScaleOne;
      cfg_q.depth_o <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegCosZ:   cfg_q.cos_z   <= cfg_data_i[TrigW-1:0];
        RegSinZ:   cfg_q.sin_z   <= cfg_data_i[TrigW-1:0];
        RegCosX:   cfg_q.cos_x   <= cfg_data_i[TrigW-1:0];
        RegSinX:   cfg_q.sin_x   <= cfg_data_i[TrigW-1:0];
        RegProjX:  cfg_q.proj_x  <= cfg_data_i;
        RegProjY:  cfg_q.proj_y  <= cfg_data_i;
        RegDepthS: cfg_q.depth_s <= cfg_data_i;
        RegDepthO: cfg_q.depth_o <= cfg_data_i;
        default:   ;  // unknown index, write dropped
      endcase
    end
  end

  // rotation
  logic                  rot_valid;
  logic signed [RxW-1:0] rot_x;
  logic signed [RzW-1:0] rot_y, rot_z;

  vrp_rotate u_rotate (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .valid_i   (s_tvalid_i),
    .x_i       (s_tdata_i[15:0]),
    .y_i       (s_tdata_i[31:16]),
    .z_i       (s_tdata_i[47:32]),
    .cfg_i     (cfg_q),
    .valid_o   (rot_valid),
    .rx_o      (rot_x),
    .ry_o      (rot_y),
    .rz_o      (rot_z)
  );

  // projection numerators and divisor
  logic            prj_valid;
  logic [NumW-1:0] prj_num [Lanes];
  logic            prj_neg [Lanes];
  logic [DenW-1:0] prj_den;
  logic            prj_wz;

  vrp_project u_project (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .valid_i   (rot_valid),
    .rx_i      (rot_x),
    .ry_i      (rot_y),
    .rz_i      (rot_z),
    .cfg_i     (cfg_q),
    .valid_o   (prj_valid),
    .num_mag_o (prj_num),
    .neg_o     (prj_neg),
    .den_mag_o (prj_den),
    .wzero_o   (prj_wz)
  );

  // perspective divide, floored
  logic                   div_valid;
  logic signed [QuoW-1:0] div_quo [Lanes];
  logic                   div_wz;

  vrp_divider u_divider (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .valid_i   (prj_valid),
    .num_mag_i (prj_num),
    .neg_i     (prj_neg),
    .den_mag_i (prj_den),
    .wzero_i   (prj_wz),
    .valid_o   (div_valid),
    .quo_o     (div_quo),
    .wzero_o   (div_wz)
  );

  // viewport mapping, output register
  logic signed [CoordW-1:0] scr_x, scr_y;
  logic signed [ScaleW-1:0] depth;
  logic                     out_wz;

  vrp_viewport #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_viewport (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .advance_i  (advance),
    .valid_i    (div_valid),
    .quo_i      (div_quo),
    .wzero_i    (div_wz),
    .valid_o    (m_tvalid_o),
    .screen_x_o (scr_x),
    .screen_y_o (scr_y),
    .depth_o    (depth),
    .wzero_o    (out_wz)
  );

  assign m_tdata_o = {depth, scr_y, scr_x};
  assign m_tuser_o = out_wz;

endmodule

// ===== tb/tb.sv =====
// testbench for the vertex transform core: rotates, projects and maps vertices
// and compares every result word against a predictor in the scoreboard class
// depends on vrp_pkg and vertex_rotate_project_viewport_core
`timescale 1ns / 1ps

module tb;
  import vrp_pkg::*;

  localparam int unsigned Latency = 69;
  localparam int unsigned StallLimit = 20000;

  typedef struct packed {
    logic [15:0] sx;
    logic [15:0] sy;
    logic [31:0] depth;
    logic        wzero;
  } pixel_t;

  // scoreboard: holds the register copy, predicts each vertex, checks results
  class vertex_scoreboard;
    longint cz, sz, cx, sx, pxs, pys, dscl, doff;
    pixel_t pending[$];
    int errors;

    function void reset_regs();
      cz = 16384; sz = 0; cx = 16384; sx = 0;
      pxs = 65536; pys = 65536; dscl = 65536; doff = 0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [31:0] val);
      case (idx)
        RegCosZ:   cz   = longint'($signed(val[15:0]));
        RegSinZ:   sz   = longint'($signed(val[15:0]));
        RegCosX:   cx   = longint'($signed(val[15:0]));
        RegSinX:   sx   = longint'($signed(val[15:0]));
        RegProjX:  pxs  = longint'($signed(val));
        RegProjY:  pys  = longint'($signed(val));
        RegDepthS: dscl = longint'($signed(val));
        RegDepthO: doff = longint'($signed(val));
        default: ;
      endcase
    endfunction

    static function longint floor_shift(longint v, int s);
      return v >>> s;
    endfunction

    static function longint floor_quot(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d != 0) && ((n < 0) != (d < 0))) q -= 1;
      return q;
    endfunction

    static function logic [15:0] to_pixel(longint ndc, longint size);
      longint c, s;
      c = ndc;
      if (c < -(64'sd1 <<< 40)) c = -(64'sd1 <<< 40);
      if (c > (64'sd1 <<< 40)) c = 64'sd1 <<< 40;
      s = ((c + 65536) * size) >>> 17;
      if (s < -32768) s = -32768;
      if (s > 32767) s = 32767;
      return s[15:0];
    endfunction

    function void note_vertex(logic [47:0] d);
      longint x, y, z, x1, y1, y2, z2, rx, ry, rz, px, py, pz, nx, ny, nz;
      pixel_t e;
      x = longint'($signed(d[15:0]));
      y = longint'($signed(d[31:16]));
      z = longint'($signed(d[47:32]));
      x1 = x * cz - y * sz;
      y1 = x * sz + y * cz;
      y2 = y1 * cx - z * sx * 16384;
      z2 = y1 * sx + z * cx * 16384;
      rx = floor_shift(x1, 10);
      ry = floor_shift(y2, 24);
      rz = floor_shift(z2, 24);
      px = rx * pxs;
      py = ry * pys;
      pz = rz * dscl + doff * 65536;
      e.wzero = (rz == 0);
      if (!e.wzero) begin
        nx = floor_quot(px, rz);
        ny = floor_quot(py, rz);
        nz = floor_quot(pz, rz);
      end else begin
        nx = px >>> 16;
        ny = py >>> 16;
        nz = pz >>> 16;
      end
      e.sx = to_pixel(nx, DefScreenWidth);
      e.sy = to_pixel(ny, DefScreenHeight);
      if (nz < -64'sd2147483648) nz = -64'sd2147483648;
      if (nz > 64'sd2147483647) nz = 64'sd2147483647;
      e.depth = nz[31:0];
      pending.push_back(e);
    endfunction

    function void report(string what, longint got, longint want);
      $display("mismatch %s: got %0h expected %0h", what, got, want);
      errors++;
    endfunction

    function void check_pixel(logic [63:0] d, logic u);
      pixel_t e;
      if (pending.size() == 0) begin
        report("unexpected word", d, 0);
        return;
      end
      e = pending.pop_front();
      if (d[15:0] !== e.sx) report("screen_x", d[15:0], e.sx);
      if (d[31:16] !== e.sy) report("screen_y", d[31:16], e.sy);
      if (d[63:32] !== e.depth) report("depth_out", d[63:32], e.depth);
      if (u !== e.wzero) report("w_was_zero", u, e.wzero);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_tvalid_i = 1'b0;
  logic s_tready_o;
  logic [47:0] s_tdata_i = '0;
  logic m_tvalid_o;
  logic m_tready_i = 1'b0;
  logic [63:0] m_tdata_o;
  logic [0:0] m_tuser_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  vertex_scoreboard sb;
  int idle_cycles = 0;
  bit hold_sink = 1'b0;  // long receiver hold-off, set by the stimulus

  vertex_rotate_project_viewport_core i_dut (.*);

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // random gap length: mostly short, sometimes long
  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(3);
    return $urandom_range(40, 10);
  endfunction

  // result side: check on the rising edge, change tready on the falling edge
  initial begin
    int g;
    g = 0;
    forever begin
      @(posedge clk_i);
      if (m_tvalid_o && m_tready_i) sb.check_pixel(m_tdata_o, m_tuser_o[0]);
      @(negedge clk_i);
      if (hold_sink) m_tready_i <= 1'b0;
      else if (g > 0) begin
        m_tready_i <= 1'b0;
        g--;
      end else begin
        m_tready_i <= 1'b1;
        if ($urandom_range(9) == 0) g = gap_len();
      end
    end
  end

  // watchdog: cycles with no word moving on any channel
  initial begin
    forever begin
      @(posedge clk_i);
      if ((s_tvalid_i && s_tready_o) || (m_tvalid_o && m_tready_i) ||
          (cfg_valid_i && cfg_ready_o) || hold_sink)
        idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles > StallLimit) begin
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  task automatic send_vertex(logic [47:0] d, bit gaps);
    int g;
    g = gaps ? (($urandom_range(3) == 0) ? gap_len() : 0) : 0;
    repeat (g) begin
      s_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i <= d;
    do @(posedge clk_i); while (!s_tready_o);
    sb.note_vertex(d);
    @(negedge clk_i);
  endtask

  // each write lowers cfg_valid_i again before returning, keeping valid changes in separate steps
  task automatic write_reg(cfg_reg_e idx, logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // let everything in flight come out before touching registers
  task automatic drain();
    s_tvalid_i <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (Latency + 4) @(negedge clk_i);
  endtask

  function automatic logic [15:0] rand_trig();
    case ($urandom_range(5))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'h8000;
      3: return 16'h0000;
      default: return 16'($urandom_range(32768) - 16384);
    endcase
  endfunction

  function automatic logic [31:0] rand_scale();
    case ($urandom_range(6))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'd65536;
      3: return 32'h0;
      4: return $urandom();
      default: return $urandom_range(262144) - 131072;
    endcase
  endfunction

  // vertex fields: extremes, small values (likely zero w) and full range
  function automatic logic [15:0] rand_coord();
    case ($urandom_range(7))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'($urandom_range(8) - 4);
      default: return 16'($urandom());
    endcase
  endfunction

  initial begin
    logic [15:0] edges [6];
    cfg_reg_e r;
    sb = new();
    sb.reset_regs();
    edges = '{16'h0000, 16'h7fff, 16'h8000, 16'h0001, 16'hffff, 16'h1000};
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: identity transform, zero w, field extremes
    for (int i = 0; i < 6; i++) send_vertex({edges[i], edges[(i + 1) % 6],
                                             edges[(i + 2) % 6]}, 1'b0);
    send_vertex(48'h0, 1'b0);
    send_vertex({16'h0000, 16'h7fff, 16'h8000}, 1'b0);
    drain();
    // out-of-range cosines, extreme scales, and an index past the list
    write_reg(RegCosZ, 32'h8000);
    write_reg(RegSinZ, 32'h7fff);
    write_reg(RegCosX, 32'h8000);
    write_reg(RegSinX, 32'h8000);
    write_reg(RegProjX, 32'h7fffffff);
    write_reg(RegProjY, 32'h80000000);
    write_reg(RegDepthS, 32'h80000000);
    write_reg(RegDepthO, 32'h7fffffff);
    write_reg(cfg_reg_e'(8'd200), $urandom());
    for (int i = 0; i < 6; i++) send_vertex({edges[(i + 3) % 6], edges[i],
                                             edges[(i + 4) % 6]}, 1'b0);
    send_vertex(48'h0, 1'b0);
    send_vertex({16'h7fff, 16'h8000, 16'h7fff}, 1'b0);

    // receiver holds off while the sender keeps offering, filling the pipe
    fork
      begin
        hold_sink = 1'b1;
        repeat (Latency * 2) @(negedge clk_i);
        hold_sink = 1'b0;
      end
      for (int i = 0; i < 100; i++)
        send_vertex({rand_coord(), rand_coord(), rand_coord()}, 1'b0);
    join
    drain();

    // random phases with new settings; phase ends with a full drain
    for (int ph = 0; ph < 9; ph++) begin
      for (int k = 0; k < 8; k++) begin
        r = cfg_reg_e'(k);
        if ($urandom_range(2) != 0 || ph == 0)
          write_reg(r, (k < 4) ? {16'h0, rand_trig()} : rand_scale());
      end
      if (ph == 8) begin
        r = RegCosZ;
        sb.reset_regs();
        for (int k = 0; k < 8; k++) begin
          r = cfg_reg_e'(k);
          write_reg(r, (k == 0 || k == 2) ? 32'd16384 :
                       (k == 4 || k == 5 || k == 6) ? 32'd65536 : 32'd0);
        end
      end
      for (int i = 0; i < 100; i++)
        send_vertex({rand_coord(), rand_coord(), rand_coord()}, 1'b1);
      drain();
    end

    if (sb.errors == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/core/vrp_pkg.sv
rtl/core/vrp_rotate.sv
rtl/core/vrp_project.sv
rtl/core/vrp_divider.sv
rtl/core/vrp_viewport.sv
rtl/core/vertex_rotate_project_viewport_core.sv
tb/tb.sv
